[sv/lcdw_pkg.sv]
// Shared types, constants and codes for the character display nibble writer.
`timescale 1ns / 1ps

package lcdw_pkg;

    localparam int LINE_CELLS    = 16;
    localparam int CNT_MAX       = 63;
    localparam int BAR_MAX_PCT   = 100;
    localparam int BAR_MAX_CELLS = 16;
    localparam int CELL_PIX      = 5;
    // x / 20 for x <= 1600: (x >> 2) * 205 >> 10
    localparam int DIV5_MUL      = 205;
    localparam int DIV5_SHIFT    = 10;

    localparam logic [2:0] OP_INIT       = 3'd0;
    localparam logic [2:0] OP_CLEAR      = 3'd1;
    localparam logic [2:0] OP_GOTO       = 3'd2;
    localparam logic [2:0] OP_PUT_CHAR   = 3'd3;
    localparam logic [2:0] OP_BAR        = 3'd4;
    localparam logic [2:0] OP_CURSOR_OFF = 3'd5;
    localparam logic [2:0] OP_CGRAM      = 3'd6;
    localparam logic [2:0] OP_RAW_DATA   = 3'd7;

    localparam logic [2:0] ALU_GOTO = 3'd0;
    localparam logic [2:0] ALU_INC  = 3'd1;
    localparam logic [2:0] ALU_MUL  = 3'd2;
    localparam logic [2:0] ALU_DIV  = 3'd3;
    localparam logic [2:0] ALU_SUB5 = 3'd4;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    localparam logic [3:0] NIB_WAKE = 4'h3;
    localparam logic [3:0] NIB_4BIT = 4'h2;

    localparam logic [7:0] CMD_FUNC_SET   = 8'h28;
    localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] CMD_DISP_ON    = 8'h0D;
    localparam logic [7:0] CMD_CLEAR      = 8'h01;
    localparam logic [7:0] CMD_DDRAM      = 8'h80;
    localparam logic [7:0] LINE2_OFS      = 8'h40;
    localparam logic [7:0] CMD_CURSOR_OFF = 8'h0C;
    localparam logic [7:0] CMD_CGRAM      = 8'h40;
    localparam logic [7:0] CHAR_FULL      = 8'h05;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] character;
        logic [4:0] column;
        logic [1:0] row;
        logic [6:0] bar_percent;
        logic [4:0] bar_cells;
    } t_in;

    typedef struct packed {
        logic       register_select;
        logic [3:0] nibble;
        logic       last;
    } t_out;

    typedef struct packed {
        logic [2:0]  op;
        logic [10:0] a;
        logic [4:0]  b;
    } t_alu_req;

endpackage

[sv/lcdw_alu.sv]
// Shared arithmetic unit: address count, saturating increment, bar scaling.
`timescale 1ns / 1ps

module lcdw_alu (
    input  lcdw_pkg::t_alu_req i_req,
    output logic [10:0]        o_y
);

    logic [7:0]  w_c;
    logic [7:0]  w_ly;
    logic [13:0] w_cnt;
    logic [6:0]  w_pct;
    logic [4:0]  w_cells;
    logic [16:0] w_q;

    assign w_c   = {3'd0, i_req.a[4:0]} - 8'd1;
    assign w_ly  = {6'd0, i_req.b[1:0]} - 8'd1;
    assign w_cnt = 14'(w_ly) * 14'(lcdw_pkg::LINE_CELLS) + 14'(w_c);
    assign w_pct = (i_req.a[6:0] > 7'(lcdw_pkg::BAR_MAX_PCT)) ?
                   7'(lcdw_pkg::BAR_MAX_PCT) : i_req.a[6:0];
    assign w_cells = (i_req.b > 5'(lcdw_pkg::BAR_MAX_CELLS)) ?
                     5'(lcdw_pkg::BAR_MAX_CELLS) : i_req.b;
    assign w_q = 17'(i_req.a[10:2]) * 17'(lcdw_pkg::DIV5_MUL);

    always_comb begin
        unique case (i_req.op)
            lcdw_pkg::ALU_GOTO: begin
                o_y = (w_cnt > 14'(lcdw_pkg::CNT_MAX)) ?
                      11'(lcdw_pkg::CNT_MAX) : {5'd0, w_cnt[5:0]};
            end
            lcdw_pkg::ALU_INC: begin
                o_y = (i_req.a[5:0] < 6'(lcdw_pkg::CNT_MAX)) ?
                      {5'd0, i_req.a[5:0] + 6'd1} : {5'd0, i_req.a[5:0]};
            end
            lcdw_pkg::ALU_MUL: begin
                o_y = 11'(w_pct) * 11'(w_cells);
            end
            lcdw_pkg::ALU_DIV: begin
                o_y = 11'(w_q >> lcdw_pkg::DIV5_SHIFT);
            end
            lcdw_pkg::ALU_SUB5: begin
                o_y = i_req.a - 11'(lcdw_pkg::CELL_PIX);
            end
            default: begin
                o_y = i_req.a;
            end
        endcase
    end

endmodule

[sv/lcdw_seq.sv]
// Opcode sequencer: expands one item into command and data nibbles.
`timescale 1ns / 1ps

module lcdw_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lcdw_pkg::t_in  i_in_data,
    input  logic           i_can_load,
    output logic           o_load,
    output lcdw_pkg::t_out o_nib
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INIT_NIB = 4'd1;
    localparam logic [3:0] S_INIT_CMD = 4'd2;
    localparam logic [3:0] S_CLR      = 4'd3;
    localparam logic [3:0] S_HOME     = 4'd4;
    localparam logic [3:0] S_GOTO     = 4'd5;
    localparam logic [3:0] S_PUT      = 4'd6;
    localparam logic [3:0] S_PUT_DATA = 4'd7;
    localparam logic [3:0] S_BAR_MUL  = 4'd8;
    localparam logic [3:0] S_BAR_DIV  = 4'd9;
    localparam logic [3:0] S_BAR_CELL = 4'd10;
    localparam logic [3:0] S_BYTE     = 4'd11;

    logic [3:0]  r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;
    logic [7:0]  r_char, n_char;
    logic [4:0]  r_col, n_col;
    logic [1:0]  r_row, n_row;
    logic [6:0]  r_pct, n_pct;
    logic [4:0]  r_cells, n_cells;
    logic [1:0]  r_idx, n_idx;
    logic [10:0] r_v, n_v;
    logic [4:0]  r_left, n_left;
    logic [7:0]  r_byte, n_byte;
    logic        r_rs, n_rs;
    logic        r_lo, n_lo;
    logic        r_blast, n_blast;
    logic [3:0]  r_ret, n_ret;
    logic        r_bar, n_bar;
    logic        r_final, n_final;

    lcdw_pkg::t_alu_req w_req;
    logic [10:0]        w_y;
    logic [7:0]         w_addr;
    logic [7:0]         w_col0;
    logic [4:0]         w_cells_c;
    logic [7:0]         w_init_cmd;

    lcdw_alu u_alu (
        .i_req (w_req),
        .o_y   (w_y)
    );

    assign w_col0    = {3'd0, r_col} - 8'd1;
    assign w_addr    = lcdw_pkg::CMD_DDRAM | ((r_row != 2'd1) ? lcdw_pkg::LINE2_OFS : 8'h00)
                       | w_col0;
    assign w_cells_c = (r_cells > 5'(lcdw_pkg::BAR_MAX_CELLS)) ?
                       5'(lcdw_pkg::BAR_MAX_CELLS) : r_cells;

    always_comb begin
        unique case (r_idx)
            2'd0:    w_init_cmd = lcdw_pkg::CMD_FUNC_SET;
            2'd1:    w_init_cmd = lcdw_pkg::CMD_ENTRY_MODE;
            default: w_init_cmd = lcdw_pkg::CMD_DISP_ON;
        endcase
    end

    always_comb begin
        w_req.a  = {5'd0, r_cnt};
        w_req.b  = 5'd0;
        w_req.op = lcdw_pkg::ALU_INC;
        unique case (r_state)
            S_GOTO: begin
                w_req.op = lcdw_pkg::ALU_GOTO;
                w_req.a  = {6'd0, r_col};
                w_req.b  = {3'd0, r_row};
            end
            S_BAR_MUL: begin
                w_req.op = lcdw_pkg::ALU_MUL;
                w_req.a  = {4'd0, r_pct};
                w_req.b  = r_cells;
            end
            S_BAR_DIV: begin
                w_req.op = lcdw_pkg::ALU_DIV;
                w_req.a  = r_v;
            end
            S_BAR_CELL: begin
                w_req.op = lcdw_pkg::ALU_SUB5;
                w_req.a  = r_v;
            end
            default: begin
                w_req.op = lcdw_pkg::ALU_INC;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_char  = r_char;
        n_col   = r_col;
        n_row   = r_row;
        n_pct   = r_pct;
        n_cells = r_cells;
        n_idx   = r_idx;
        n_v     = r_v;
        n_left  = r_left;
        n_byte  = r_byte;
        n_rs    = r_rs;
        n_lo    = r_lo;
        n_blast = r_blast;
        n_ret   = r_ret;
        n_bar   = r_bar;
        n_final = r_final;
        o_load  = 1'b0;
        o_nib.register_select = r_rs;
        o_nib.nibble          = r_lo ? r_byte[3:0] : r_byte[7:4];
        o_nib.last            = r_lo & r_blast;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_char  = i_in_data.character;
                    n_col   = i_in_data.column;
                    n_row   = i_in_data.row;
                    n_pct   = i_in_data.bar_percent;
                    n_cells = i_in_data.bar_cells;
                    n_idx   = 2'd0;
                    n_lo    = 1'b0;
                    n_bar   = 1'b0;
                    n_final = 1'b1;
                    n_ret   = S_IDLE;
                    n_blast = 1'b1;
                    n_rs    = lcdw_pkg::RS_CMD;
                    unique case (i_in_data.opcode)
                        lcdw_pkg::OP_INIT:     n_state = S_INIT_NIB;
                        lcdw_pkg::OP_CLEAR:    n_state = S_CLR;
                        lcdw_pkg::OP_GOTO:     n_state = S_GOTO;
                        lcdw_pkg::OP_PUT_CHAR: n_state = S_PUT;
                        lcdw_pkg::OP_BAR:      n_state = S_BAR_MUL;
                        lcdw_pkg::OP_CURSOR_OFF: begin
                            n_byte  = lcdw_pkg::CMD_CURSOR_OFF;
                            n_state = S_BYTE;
                        end
                        lcdw_pkg::OP_CGRAM: begin
                            n_byte  = lcdw_pkg::CMD_CGRAM;
                            n_state = S_BYTE;
                        end
                        default: begin
                            n_byte  = i_in_data.character;
                            n_rs    = lcdw_pkg::RS_DATA;
                            n_state = S_BYTE;
                        end
                    endcase
                end
            end
            S_INIT_NIB: begin
                o_nib.register_select = lcdw_pkg::RS_CMD;
                o_nib.nibble          = (r_idx == 2'd3) ? lcdw_pkg::NIB_4BIT
                                                        : lcdw_pkg::NIB_WAKE;
                o_nib.last            = 1'b0;
                if (i_can_load) begin
                    o_load = 1'b1;
                    n_idx  = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        n_state = S_INIT_CMD;
                    end
                end
            end
            S_INIT_CMD: begin
                n_byte  = w_init_cmd;
                n_rs    = lcdw_pkg::RS_CMD;
                n_blast = 1'b0;
                n_lo    = 1'b0;
                n_idx   = r_idx + 2'd1;
                n_ret   = (r_idx == 2'd2) ? S_CLR : S_INIT_CMD;
                n_state = S_BYTE;
            end
            S_CLR: begin
                n_byte  = lcdw_pkg::CMD_CLEAR;
                n_rs    = lcdw_pkg::RS_CMD;
                n_blast = 1'b0;
                n_lo    = 1'b0;
                n_ret   = S_HOME;
                n_state = S_BYTE;
            end
            S_HOME: begin
                n_byte  = lcdw_pkg::CMD_DDRAM;
                n_rs    = lcdw_pkg::RS_CMD;
                n_blast = 1'b1;
                n_lo    = 1'b0;
                n_cnt   = 6'd0;
                n_ret   = S_IDLE;
                n_state = S_BYTE;
            end
            S_GOTO: begin
                n_byte  = w_addr;
                n_rs    = lcdw_pkg::RS_CMD;
                n_blast = 1'b1;
                n_lo    = 1'b0;
                n_cnt   = w_y[5:0];
                n_ret   = S_IDLE;
                n_state = S_BYTE;
            end
            S_PUT: begin
                if (r_cnt == 6'(lcdw_pkg::LINE_CELLS)) begin
                    n_byte  = lcdw_pkg::CMD_DDRAM | lcdw_pkg::LINE2_OFS;
                    n_rs    = lcdw_pkg::RS_CMD;
                    n_blast = 1'b0;
                    n_lo    = 1'b0;
                    n_ret   = S_PUT_DATA;
                    n_state = S_BYTE;
                end else begin
                    n_state = S_PUT_DATA;
                end
            end
            S_PUT_DATA: begin
                n_byte  = r_char;
                n_rs    = lcdw_pkg::RS_DATA;
                n_blast = r_final;
                n_lo    = 1'b0;
                n_cnt   = w_y[5:0];
                n_ret   = (r_bar && !r_final) ? S_BAR_CELL : S_IDLE;
                n_state = S_BYTE;
            end
            S_BAR_MUL: begin
                n_v    = w_y;
                n_left = w_cells_c;
                n_bar  = 1'b1;
                n_state = (w_cells_c == 5'd0) ? S_IDLE : S_BAR_DIV;
            end
            S_BAR_DIV: begin
                n_v     = w_y;
                n_state = S_BAR_CELL;
            end
            S_BAR_CELL: begin
                if (r_v > 11'(lcdw_pkg::CELL_PIX)) begin
                    n_char  = lcdw_pkg::CHAR_FULL;
                    n_v     = w_y;
                    n_final = (r_left == 5'd1);
                end else begin
                    n_char  = r_v[7:0];
                    n_final = 1'b1;
                end
                n_left  = r_left - 5'd1;
                n_state = S_PUT;
            end
            S_BYTE: begin
                if (i_can_load) begin
                    o_load = 1'b1;
                    n_lo   = ~r_lo;
                    if (r_lo) begin
                        n_state = r_ret;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 6'd0;
            r_lo    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_lo    <= n_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_col   <= n_col;
        r_row   <= n_row;
        r_pct   <= n_pct;
        r_cells <= n_cells;
        r_idx   <= n_idx;
        r_v     <= n_v;
        r_left  <= n_left;
        r_byte  <= n_byte;
        r_rs    <= n_rs;
        r_blast <= n_blast;
        r_ret   <= n_ret;
        r_bar   <= n_bar;
        r_final <= n_final;
    end

endmodule

[sv/char_lcd_4bit_command_writer.sv]
// Top level: 4-bit character display command writer with output register.
//
//   channel   direction   handshake                  payload
//   in        sink        i_in_valid / o_in_ready    i_in_data  (t_in)
//   out       source      o_out_valid / i_out_ready  o_out_data (t_out)
//
// One nibble leaves per cycle while a byte streams and the output is not stalled.
// Init sends the wake nibbles and setup commands; a bar graph runs each cell
// through the shared unit and adds a line-wrap command when the first row fills.
// Reset is synchronous and clears the sequencer, the cell counter and the output
// valid flag. A stalled output holds the sequencer; a new item is taken while
// the last nibble of the previous one still waits in the output register.
`timescale 1ns / 1ps

module char_lcd_4bit_command_writer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lcdw_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lcdw_pkg::t_out o_out_data
);

    logic           r_out_valid;
    lcdw_pkg::t_out r_out;
    logic           w_can_load;
    logic           w_load;
    lcdw_pkg::t_out w_nib;

    assign w_can_load = !r_out_valid || i_out_ready;

    lcdw_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_can_load (w_can_load),
        .o_load     (w_load),
        .o_nib      (w_nib)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_nib;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_load_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_can_load)
        else $error("nibble loaded over a pending transfer");

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> !o_in_ready)
        else $error("input taken before the run finished");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("sequencer stayed idle after an input transfer");

endmodule
